/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the compressor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SHA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define SHA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define SHA_ASSERT(lbl, clk, rst_n, prop)

`define SHA_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* hw/rtl/sha_bc_pkg.sv */
// Constants, tables and round functions of the SHA-256 block compressor.
package sha_bc_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned HashWords  = 8;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned HashAddrW  = $clog2(HashWords);
  localparam int unsigned BlockCntW  = $clog2(BlockWords);
  localparam int unsigned RoundCntW  = $clog2(Rounds);

  typedef logic [WordW-1:0] word_t;

  localparam logic MODE_SHA256 = 1'b0;
  localparam logic MODE_SHA224 = 1'b1;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t iv_word(input logic mode, input logic [HashAddrW-1:0] idx);
    word_t w;
    w = '0;
    if (mode == MODE_SHA224) begin
      case (idx)
        3'd0: w = 32'hc1059ed8;
        3'd1: w = 32'h367cd507;
        3'd2: w = 32'h3070dd17;
        3'd3: w = 32'hf70e5939;
        3'd4: w = 32'hffc00b31;
        3'd5: w = 32'h68581511;
        3'd6: w = 32'h64f98fa7;
        3'd7: w = 32'hbefa4fa4;
        default: w = '0;
      endcase
    end else begin
      case (idx)
        3'd0: w = 32'h6a09e667;
        3'd1: w = 32'hbb67ae85;
        3'd2: w = 32'h3c6ef372;
        3'd3: w = 32'ha54ff53a;
        3'd4: w = 32'h510e527f;
        3'd5: w = 32'h9b05688c;
        3'd6: w = 32'h1f83d9ab;
        3'd7: w = 32'h5be0cd19;
        default: w = '0;
      endcase
    end
    iv_word = w;
  endfunction

  function automatic word_t round_const(input logic [RoundCntW-1:0] idx);
    word_t k;
    k = '0;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    round_const = k;
  endfunction

endpackage

/* hw/rtl/sha_bc_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module sha_bc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/sha256_block_compressor_unit.sv */
// Top level of the SHA-256/SHA-224 block compressor with the hash held in RAM.
// A block takes 16 accepted words, then the hash is loaded, 64 rounds run at one per
// cycle and the result is added back into the hash RAM. After the write-back of a final
// block the digest words follow one by one, each read from the single hash RAM port
// and held while the output stalls.
// After reset the hash reads as the SHA-256 initial values without any clearing pass.
`include "assert_macros.svh"

module sha256_block_compressor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] message_word_i,
  input  logic        first_of_message_i,
  input  logic        final_block_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_o
);

  localparam int unsigned AW = sha_bc_pkg::HashAddrW;
  localparam int unsigned BW = sha_bc_pkg::BlockWords;
  localparam int unsigned HW = sha_bc_pkg::HashWords;
  localparam int unsigned RW = sha_bc_pkg::RoundCntW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_WB,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_e;

  state_e                          state_q;
  logic                            digest_mode_q;
  logic                            iv_flag_q;
  logic                            iv_mode_q;
  logic                            final_q;
  logic [sha_bc_pkg::BlockCntW-1:0] word_cnt_q;
  logic [AW:0]                     ptr_q;
  logic [RW-1:0]                   rnd_q;
  logic [AW-1:0]                   emit_idx_q;
  logic                            out_valid_q;
  sha_bc_pkg::word_t               out_word_q;
  logic [AW-1:0]                   out_idx_q;
  logic                            out_last_q;

  sha_bc_pkg::word_t w_q [BW];
  sha_bc_pkg::word_t v_q [HW];
  logic [AW-1:0]     rd_addr_q;

  logic              in_xfer;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  sha_bc_pkg::word_t ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  sha_bc_pkg::word_t ram_rdata;
  sha_bc_pkg::word_t hash_rd;
  logic [sha_bc_pkg::BlockCntW-1:0] word_cnt_d;
  logic [AW-1:0]     last_idx;
  logic              out_free;

  sha_bc_pkg::word_t t1, t2, ch, maj, w_new;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_idx    = (digest_mode_q == sha_bc_pkg::MODE_SHA224) ? AW'(HW - 2) : AW'(HW - 1);
  assign word_cnt_d  = (first_of_message_i ? '0 : word_cnt_q) + 1'b1;

  assign hash_rd = iv_flag_q ? sha_bc_pkg::iv_word(iv_mode_q, rd_addr_q) : ram_rdata;

  always_comb begin
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = v_q[7] + sha_bc_pkg::big_sigma1(v_q[4]) + ch + sha_bc_pkg::round_const(rnd_q)
          + w_q[0];
    t2    = sha_bc_pkg::big_sigma0(v_q[0]) + maj;
    w_new = sha_bc_pkg::small_sigma1(w_q[14]) + w_q[9] + sha_bc_pkg::small_sigma0(w_q[1])
          + w_q[0];
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr_q[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0] - 1'b1;
    ram_wdata = hash_rd + v_q[0];
    case (state_q)
      ST_LOAD: begin
        ram_re = !ptr_q[AW];
      end
      ST_WB: begin
        ram_re = !ptr_q[AW];
        ram_we = (ptr_q != '0);
      end
      ST_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = emit_idx_q;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  sha_bc_ram #(
    .Width(sha_bc_pkg::WordW),
    .Depth(HW)
  ) u_hash_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      digest_mode_q <= sha_bc_pkg::MODE_SHA256;
      iv_flag_q     <= 1'b1;
      iv_mode_q     <= sha_bc_pkg::MODE_SHA256;
      final_q       <= 1'b0;
      word_cnt_q    <= '0;
      ptr_q         <= '0;
      rnd_q         <= '0;
      emit_idx_q    <= '0;
      out_valid_q   <= 1'b0;
      out_word_q    <= '0;
      out_idx_q     <= '0;
      out_last_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        digest_mode_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i && state_q != ST_EMIT_WAIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            word_cnt_q <= word_cnt_d;
            if (first_of_message_i) begin
              iv_flag_q <= 1'b1;
              iv_mode_q <= digest_mode_q;
            end
            if (word_cnt_d == '0) begin
              final_q <= final_block_i;
              ptr_q   <= '0;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q[AW]) begin
            rnd_q   <= '0;
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == RW'(sha_bc_pkg::Rounds - 1)) begin
            ptr_q   <= '0;
            state_q <= ST_WB;
          end
        end
        ST_WB: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q[AW]) begin
            iv_flag_q  <= 1'b0;
            emit_idx_q <= '0;
            state_q    <= final_q ? ST_EMIT_RD : ST_IDLE;
          end
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_word_q  <= hash_rd;
            out_idx_q   <= emit_idx_q;
            out_last_q  <= (emit_idx_q == last_idx);
            emit_idx_q  <= emit_idx_q + 1'b1;
            state_q     <= (emit_idx_q == last_idx) ? ST_IDLE : ST_EMIT_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rd_addr_q <= ram_raddr;
    end
    if (in_xfer || state_q == ST_ROUND) begin
      for (int i = 0; i < BW - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BW-1] <= in_xfer ? message_word_i : w_new;
    end
    if ((state_q == ST_LOAD || state_q == ST_WB) && ptr_q != '0) begin
      for (int i = 0; i < HW - 1; i++) begin
        v_q[i] <= v_q[i+1];
      end
      v_q[HW-1] <= (state_q == ST_LOAD) ? hash_rd : v_q[0];
    end else if (state_q == ST_ROUND) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_o        = out_last_q;

  `SHA_ASSERT(a_emit_after_wb, clk_i, rst_ni, $rose(out_valid_o) |-> !iv_flag_q)
  `SHA_ASSERT(a_last_idx, clk_i, rst_ni, (out_valid_o && last_o) |-> (word_index_o == last_idx))
  `SHA_ASSERT(a_rounds_end, clk_i, rst_ni,
              (state_q == ST_ROUND && rnd_q == RW'(sha_bc_pkg::Rounds - 1)) |=> (state_q == ST_WB))
  `SHA_ASSERT_NEVER(a_ram_rw_same, clk_i, rst_ni, ram_we && ram_re && (ram_waddr == ram_raddr))

endmodule
